### design/salc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, constants and helpers for the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;

    localparam int ADDR_W   = 64;
    localparam int TAG_W    = 64;
    localparam int STAMP_W  = 32;
    localparam int CNT_W    = 32;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NSETS    = 1 << MAX_SET_BITS;
    localparam int WAY_IW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int NPAIR    = (MAX_WAYS + 1) / 2;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam int SB_W     = 3;
    localparam int BB_W     = 5;
    localparam int WIU_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam int OUTCOME_W  = 2;
    localparam int WAY_USED_W = 3;
    localparam int OUT_BITS   = OUTCOME_W + WAY_USED_W + 2 * CNT_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_HIT   = 2'd0,
        OC_COLD  = 2'd1,
        OC_EVICT = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SET_W-1:0]  set;
        logic [WCNT_W-1:0] ways;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_qhead;

    typedef struct packed {
        logic [MAX_WAYS-1:0]              valid;
        logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp;
        logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
    } t_row;

    typedef struct packed {
        logic               en;
        logic [STAMP_W-1:0] stamp;
        logic [WAY_IW-1:0]  way;
    } t_cand;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    // a is the lower-numbered way and wins ties
    function automatic t_cand pick_old(input t_cand a, input t_cand b);
        pick_old = (a.en && (!b.en || a.stamp <= b.stamp)) ? a : b;
    endfunction

endpackage

### design/salc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_front
// Configuration registers and address decode into set index and tag.
// ----------------------------------------------------------------------------
module salc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [salc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic [salc_pkg::ADDR_W-1:0]      i_addr,
    output salc_pkg::t_req                   o_req
);

    logic [salc_pkg::SB_W-1:0]   r_set_bits;
    logic [salc_pkg::BB_W-1:0]   r_block_bits;
    logic [salc_pkg::WIU_W-1:0]  r_ways_in_use;

    logic [salc_pkg::SB_W-1:0]   sb;
    logic [salc_pkg::BB_W:0]     tag_sh;
    logic [salc_pkg::ADDR_W-1:0] off_sh;
    logic [salc_pkg::SET_W-1:0]  set_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= '0;
            r_block_bits  <= '0;
            r_ways_in_use <= salc_pkg::WIU_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                salc_pkg::CFG_SET_BITS:    r_set_bits    <= i_cfg_wdata[salc_pkg::SB_W-1:0];
                salc_pkg::CFG_BLOCK_BITS:  r_block_bits  <= i_cfg_wdata[salc_pkg::BB_W-1:0];
                salc_pkg::CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_wdata[salc_pkg::WIU_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        sb = (r_set_bits > salc_pkg::SB_W'(salc_pkg::MAX_SET_BITS))
             ? salc_pkg::SB_W'(salc_pkg::MAX_SET_BITS) : r_set_bits;
        tag_sh   = {1'b0, r_block_bits} + (salc_pkg::BB_W + 1)'(sb);
        off_sh   = i_addr >> r_block_bits;
        set_mask = ~({salc_pkg::SET_W{1'b1}} << sb);

        o_req.tag = i_addr >> tag_sh;
        o_req.set = off_sh[salc_pkg::SET_W-1:0] & set_mask;
        if (r_ways_in_use == '0) begin
            o_req.ways = salc_pkg::WCNT_W'(1);
        end else if (r_ways_in_use > salc_pkg::WIU_W'(salc_pkg::MAX_WAYS)) begin
            o_req.ways = salc_pkg::WCNT_W'(salc_pkg::MAX_WAYS);
        end else begin
            o_req.ways = salc_pkg::WCNT_W'(r_ways_in_use);
        end
    end

endmodule

### design/salc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_queue
// Short request queue between the decode front and the tag store back.
// ----------------------------------------------------------------------------
module salc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  salc_pkg::t_req  i_req,
    output logic            o_full,
    input  logic            i_pop,
    output salc_pkg::t_qhead o_head
);

    salc_pkg::t_req                r_mem [salc_pkg::QDEPTH];
    logic [salc_pkg::QPTR_W-1:0]   r_wptr, n_wptr;
    logic [salc_pkg::QPTR_W-1:0]   r_rptr, n_rptr;
    logic [salc_pkg::QCNT_W-1:0]   r_cnt,  n_cnt;
    logic                          do_push, do_pop;

    always_comb begin
        o_full       = (r_cnt == salc_pkg::QCNT_W'(salc_pkg::QDEPTH));
        o_head.valid = (r_cnt != '0);
        o_head.req   = r_mem[r_rptr];
        do_push      = i_push && !o_full;
        do_pop       = i_pop && o_head.valid;
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (do_push) begin
            n_wptr = (r_wptr == salc_pkg::QPTR_W'(salc_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == salc_pkg::QPTR_W'(salc_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        n_cnt = r_cnt + salc_pkg::QCNT_W'(do_push) - salc_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_req;
        end
    end

endmodule

### design/salc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_back
// Tag/stamp/valid memory, hit search, LRU victim choice, write-back and
// counters. After reset the memory is cleared row by row, in S_CLEAR.
// ----------------------------------------------------------------------------
module salc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  salc_pkg::t_qhead            i_head,
    output logic                        o_pop,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [salc_pkg::OUT_W-1:0]  o_m_tdata
);

    salc_pkg::t_state r_state, n_state;

    salc_pkg::t_row r_mem [salc_pkg::NSETS];
    salc_pkg::t_row r_rd;
    salc_pkg::t_row n_row;
    salc_pkg::t_req r_req;

    logic [salc_pkg::SET_W-1:0]    r_clr_idx;

    logic                          r_hit, n_hit;
    logic [salc_pkg::WAY_IW-1:0]   r_hit_way, n_hit_way;
    logic                          r_free_any, n_free_any;
    logic [salc_pkg::WAY_IW-1:0]   r_free_way, n_free_way;
    salc_pkg::t_cand               r_pair [salc_pkg::NPAIR];
    salc_pkg::t_cand               n_pair [salc_pkg::NPAIR];
    salc_pkg::t_cand               cand   [salc_pkg::MAX_WAYS];
    salc_pkg::t_cand               lru;

    logic [salc_pkg::STAMP_W-1:0]  r_stamp;
    logic [salc_pkg::CNT_W-1:0]    r_hit_cnt, n_hit_cnt;
    logic [salc_pkg::CNT_W-1:0]    r_miss_cnt, n_miss_cnt;

    logic                          r_out_valid;
    logic [salc_pkg::OUT_W-1:0]    r_out_data;

    logic                          clr_en, eval_en, done;
    logic [salc_pkg::WAY_IW-1:0]   way_fin;
    salc_pkg::t_outcome            outcome;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            salc_pkg::S_CLEAR: begin
                if (r_clr_idx == salc_pkg::SET_W'(salc_pkg::NSETS - 1)) begin
                    n_state = salc_pkg::S_IDLE;
                end
            end
            salc_pkg::S_IDLE:  if (i_head.valid) n_state = salc_pkg::S_EVAL;
            salc_pkg::S_EVAL:  n_state = salc_pkg::S_WRITE;
            salc_pkg::S_WRITE: if (!r_out_valid || i_m_tready) n_state = salc_pkg::S_IDLE;
            default:           n_state = salc_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop   = 1'b0;
        clr_en  = 1'b0;
        eval_en = 1'b0;
        done    = 1'b0;
        unique case (r_state)
            salc_pkg::S_CLEAR: clr_en  = 1'b1;
            salc_pkg::S_IDLE:  o_pop   = i_head.valid;
            salc_pkg::S_EVAL:  eval_en = 1'b1;
            salc_pkg::S_WRITE: done    = !r_out_valid || i_m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= salc_pkg::S_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (clr_en) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // compare stage
    always_comb begin
        n_hit      = 1'b0;
        n_hit_way  = '0;
        n_free_any = 1'b0;
        n_free_way = '0;
        for (int w = salc_pkg::MAX_WAYS - 1; w >= 0; w--) begin
            if (salc_pkg::WCNT_W'(w) < r_req.ways) begin
                if (r_rd.valid[w] && r_rd.tag[w] == r_req.tag) begin
                    n_hit     = 1'b1;
                    n_hit_way = salc_pkg::WAY_IW'(w);
                end
            end
        end
        for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
            if (salc_pkg::WCNT_W'(w) < r_req.ways && !r_rd.valid[w]) begin
                n_free_any = 1'b1;
                n_free_way = salc_pkg::WAY_IW'(w);
            end
        end
        for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
            cand[w].en    = (salc_pkg::WCNT_W'(w) < r_req.ways) && r_rd.valid[w];
            cand[w].stamp = r_rd.stamp[w];
            cand[w].way   = salc_pkg::WAY_IW'(w);
        end
        for (int p = 0; p < salc_pkg::NPAIR; p++) begin
            if (2 * p + 1 < salc_pkg::MAX_WAYS) begin
                n_pair[p] = salc_pkg::pick_old(cand[2 * p], cand[2 * p + 1]);
            end else begin
                n_pair[p] = cand[2 * p];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_en) begin
            r_hit      <= n_hit;
            r_hit_way  <= n_hit_way;
            r_free_any <= n_free_any;
            r_free_way <= n_free_way;
            for (int p = 0; p < salc_pkg::NPAIR; p++) begin
                r_pair[p] <= n_pair[p];
            end
        end
    end

    // decide and write-back stage
    always_comb begin
        lru = r_pair[0];
        for (int p = 1; p < salc_pkg::NPAIR; p++) begin
            lru = salc_pkg::pick_old(lru, r_pair[p]);
        end
        if (r_hit) begin
            way_fin = r_hit_way;
            outcome = salc_pkg::OC_HIT;
        end else if (r_free_any) begin
            way_fin = r_free_way;
            outcome = salc_pkg::OC_COLD;
        end else begin
            way_fin = lru.way;
            outcome = salc_pkg::OC_EVICT;
        end
        n_row                = r_rd;
        n_row.valid[way_fin] = 1'b1;
        n_row.tag[way_fin]   = r_req.tag;
        n_row.stamp[way_fin] = r_stamp;
        n_hit_cnt  = r_hit ? salc_pkg::sat_inc(r_hit_cnt) : r_hit_cnt;
        n_miss_cnt = r_hit ? r_miss_cnt : salc_pkg::sat_inc(r_miss_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (clr_en) begin
            r_mem[r_clr_idx] <= '0;
        end else if (done) begin
            r_mem[r_req.set] <= n_row;
        end
        if (o_pop) begin
            r_rd   <= r_mem[i_head.req.set];
            r_req  <= i_head.req;
        end
        if (done) begin
            r_out_data <= salc_pkg::OUT_W'({n_miss_cnt, n_hit_cnt,
                                            salc_pkg::WAY_USED_W'(way_fin), outcome});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp     <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (done) begin
                r_stamp    <= salc_pkg::sat_inc(r_stamp);
                r_hit_cnt  <= n_hit_cnt;
                r_miss_cnt <= n_miss_cnt;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_mem[$past(r_req.set)].valid[$past(way_fin)])
        else $error("filled line not marked valid");

    a_way_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (salc_pkg::WCNT_W'(way_fin) < r_req.ways))
        else $error("way outside associativity in use");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done && r_hit_cnt != '1 && r_miss_cnt != '1 |=>
        ({1'b0, r_hit_cnt} + {1'b0, r_miss_cnt}) ==
        ($past({1'b0, r_hit_cnt} + {1'b0, r_miss_cnt}) + 1'b1))
        else $error("access totals did not advance by one");
`endif

endmodule

### design/set_assoc_lru_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag store of a set-associative cache with LRU replacement and hit/miss totals.
//
//   channel  dir  handshake            payload
//   s        in   i_s_tvalid/o_s_tready address
//   m        out  o_m_tvalid/i_m_tready outcome, way_used, hit_count, miss_count
//   cfg      in   i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// In the tag store each request goes through set read from memory,
// parallel tag compare with pairwise stamp compare, then victim choice and
// row write-back. A two-entry request queue lets the input keep accepting
// while the result register waits. After reset the back clears the 64 rows
// of the store, row by row, before it takes the first request; the queue
// accepts up to two requests meanwhile.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [salc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [salc_pkg::ADDR_W-1:0]      i_s_tdata,   // [63:0] address
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [1:0] outcome, [4:2] way_used, [36:5] hit_count, [68:37] miss_count
    output logic [salc_pkg::OUT_W-1:0]       o_m_tdata
);

    salc_pkg::t_req   req;
    salc_pkg::t_qhead head;
    logic             q_full;
    logic             pop;

    salc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_addr      (i_s_tdata),
        .o_req       (req)
    );

    salc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_req   (req),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    salc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    assign o_s_tready = !q_full;

endmodule
